// ----- rtl/u2c_pkg.sv -----
// Shared widths, lead-byte constants and a decode helper for the UTF-8 decoder.
package u2c_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned GrpMax = 4;
  localparam int unsigned CntW   = $clog2(GrpMax + 1);
  localparam int unsigned LenW   = 3;
  localparam int unsigned PendW  = 2;

  localparam logic [LenW-1:0] LenBad   = 3'd0;
  localparam logic [LenW-1:0] LenOne   = 3'd1;
  localparam logic [LenW-1:0] LenTwo   = 3'd2;
  localparam logic [LenW-1:0] LenThree = 3'd3;
  localparam logic [LenW-1:0] LenFour  = 3'd4;

  localparam logic [ByteW-1:0] MaskTop1  = 8'h80;
  localparam logic [ByteW-1:0] MaskTop3  = 8'he0;
  localparam logic [ByteW-1:0] MaskTop4  = 8'hf0;
  localparam logic [ByteW-1:0] MaskTop5  = 8'hf8;
  localparam logic [ByteW-1:0] PatTwo    = 8'hc0;
  localparam logic [ByteW-1:0] PatThree  = 8'he0;
  localparam logic [ByteW-1:0] PatFour   = 8'hf0;
  localparam logic [ByteW-1:0] MaskAscii = 8'h7f;

  typedef logic [GrpMax-1:0][ByteW-1:0] grp_bytes_t;

  function automatic logic [LenW-1:0] seq_len(input logic [ByteW-1:0] b);
    logic [LenW-1:0] n;
    if ((b & MaskTop1) == '0) begin
      n = LenOne;
    end else if ((b & MaskTop3) == PatTwo) begin
      n = LenTwo;
    end else if ((b & MaskTop4) == PatThree) begin
      n = LenThree;
    end else if ((b & MaskTop5) == PatFour) begin
      n = LenFour;
    end else begin
      n = LenBad;
    end
    return n;
  endfunction

endpackage

// ----- rtl/u2c_in_if.sv -----
// Input channel: one UTF-8 byte per request with its end-of-string mark.
interface u2c_in_if;
  logic                     valid;
  logic                     ready;
  logic [u2c_pkg::ByteW-1:0] in_byte;
  logic                     end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

// ----- rtl/u2c_out_if.sv -----
// Output channel: one code point byte, terminator or error per request.
interface u2c_out_if;
  logic                     valid;
  logic                     ready;
  logic [u2c_pkg::ByteW-1:0] out_byte;
  logic                     is_terminator;
  logic                     bad_lead;
  logic                     out_last;

  modport source (output valid, output out_byte, output is_terminator, output bad_lead,
                  output out_last, input ready);
  modport sink   (input valid, input out_byte, input is_terminator, input bad_lead,
                  input out_last, output ready);
endinterface

// ----- rtl/utf8_to_codepoint_bytes.sv -----
// Top level of the UTF-8 to big-endian code point byte decoder.
// Each input byte is decoded in the cycle it is accepted; the results it causes
// (none while a sequence is still open, one for ASCII or a bad lead byte, two
// or three code point bytes when a sequence completes, plus a zero terminator
// when the end mark was seen, but not after a bad lead byte) are loaded as one
// group into a result register that the output side drains at one result per
// cycle while out ready is high. The input takes a new byte every cycle while
// each byte causes at most one result and out ready is high; a byte that causes
// more holds off the next byte until its last result is taken. Input ready stays
// high while that last result is taken, so there is no bubble between groups.
module utf8_to_codepoint_bytes (
  input  logic       clk_i,
  input  logic       rst_ni,
  u2c_in_if.sink     in_i,
  u2c_out_if.source  out_o
);

  logic [u2c_pkg::ByteW-1:0] lead_q, lead_d;
  logic [u2c_pkg::ByteW-1:0] sec_q, sec_d;
  logic [u2c_pkg::ByteW-1:0] thr_q, thr_d;
  logic [u2c_pkg::PendW-1:0] pend_q, pend_d;
  logic                      endp_q, endp_d;

  u2c_pkg::grp_bytes_t       grp_byte_q, grp_byte_d;
  logic [u2c_pkg::CntW-1:0]  grp_cnt_q, grp_cnt_d;
  logic                      grp_bad_q, grp_bad_d;
  logic                      grp_term_q, grp_term_d;

  u2c_pkg::grp_bytes_t       res_byte;
  logic [u2c_pkg::CntW-1:0]  res_cnt;
  logic                      res_bad;
  logic                      res_term;

  logic [u2c_pkg::ByteW-1:0] b;
  logic                      eos;
  logic                      endp_n;
  logic [u2c_pkg::LenW-1:0]  in_len;
  logic [u2c_pkg::LenW-1:0]  lead_len;
  logic                      in_acc;
  logic                      out_acc;
  logic                      grp_final;

  assign b        = in_i.in_byte;
  assign eos      = in_i.end_of_string;
  assign in_len   = u2c_pkg::seq_len(b);
  assign lead_len = u2c_pkg::seq_len(lead_q);
  assign endp_n   = endp_q | eos;

  assign grp_final   = (grp_cnt_q == u2c_pkg::CntW'(1));
  assign out_o.valid = (grp_cnt_q != '0);
  assign out_acc     = out_o.valid & out_o.ready;
  assign in_i.ready  = (grp_cnt_q == '0) | (out_o.ready & grp_final);
  assign in_acc      = in_i.valid & in_i.ready;

  assign out_o.out_byte      = grp_byte_q[0];
  assign out_o.bad_lead      = grp_bad_q;
  assign out_o.out_last      = grp_final;
  assign out_o.is_terminator = grp_term_q & grp_final;

  // Decode the byte against the open sequence.
  always_comb begin
    lead_d   = lead_q;
    sec_d    = sec_q;
    thr_d    = thr_q;
    pend_d   = pend_q;
    endp_d   = endp_q;
    res_byte = '0;
    res_cnt  = '0;
    res_bad  = 1'b0;
    res_term = 1'b0;
    if (pend_q == '0) begin
      unique case (in_len) inside
        u2c_pkg::LenBad: begin
          res_byte[0] = b;
          res_cnt     = u2c_pkg::CntW'(1);
          res_bad     = 1'b1;
          lead_d      = '0;
          sec_d       = '0;
          thr_d       = '0;
          endp_d      = 1'b0;
        end
        u2c_pkg::LenOne: begin
          res_byte[0] = b & u2c_pkg::MaskAscii;
          res_term    = eos;
          res_cnt     = eos ? u2c_pkg::CntW'(2) : u2c_pkg::CntW'(1);
          lead_d      = '0;
          sec_d       = '0;
          thr_d       = '0;
          endp_d      = 1'b0;
        end
        u2c_pkg::LenTwo, u2c_pkg::LenThree, u2c_pkg::LenFour: begin
          lead_d = b;
          pend_d = u2c_pkg::PendW'(in_len - u2c_pkg::LenW'(1));
          endp_d = eos;
        end
        default: begin
          lead_d = lead_q;
        end
      endcase
    end else if (pend_q > u2c_pkg::PendW'(1)) begin
      endp_d = endp_n;
      if ((lead_len == u2c_pkg::LenFour) && (pend_q == u2c_pkg::PendW'(2))) begin
        thr_d = b;
      end else begin
        sec_d = b;
      end
      pend_d = pend_q - u2c_pkg::PendW'(1);
    end else begin
      res_term = endp_n;
      unique case (lead_len)
        u2c_pkg::LenTwo: begin
          res_byte[0] = {5'b0, lead_q[4:2]};
          res_byte[1] = {lead_q[1:0], b[5:0]};
          res_cnt     = u2c_pkg::CntW'(2);
        end
        u2c_pkg::LenThree: begin
          res_byte[0] = {lead_q[3:0], sec_q[5:2]};
          res_byte[1] = {sec_q[1:0], b[5:0]};
          res_cnt     = u2c_pkg::CntW'(2);
        end
        default: begin
          res_byte[0] = {3'b0, lead_q[2:0], sec_q[5:4]};
          res_byte[1] = {sec_q[3:0], thr_q[5:2]};
          res_byte[2] = {thr_q[1:0], b[5:0]};
          res_cnt     = u2c_pkg::CntW'(3);
        end
      endcase
      if (endp_n) begin
        res_cnt = res_cnt + u2c_pkg::CntW'(1);
      end
      lead_d = '0;
      sec_d  = '0;
      thr_d  = '0;
      pend_d = '0;
      endp_d = 1'b0;
    end
  end

  // Load a new result group or advance the current one.
  always_comb begin
    grp_byte_d = grp_byte_q;
    grp_cnt_d  = grp_cnt_q;
    grp_bad_d  = grp_bad_q;
    grp_term_d = grp_term_q;
    if (out_acc) begin
      grp_byte_d = grp_byte_q >> u2c_pkg::ByteW;
      grp_cnt_d  = grp_cnt_q - u2c_pkg::CntW'(1);
    end
    if (in_acc && (res_cnt != '0)) begin
      grp_byte_d = res_byte;
      grp_cnt_d  = res_cnt;
      grp_bad_d  = res_bad;
      grp_term_d = res_term;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q     <= '0;
      sec_q      <= '0;
      thr_q      <= '0;
      pend_q     <= '0;
      endp_q     <= 1'b0;
      grp_cnt_q  <= '0;
      grp_bad_q  <= 1'b0;
      grp_term_q <= 1'b0;
    end else begin
      if (in_acc) begin
        lead_q <= lead_d;
        sec_q  <= sec_d;
        thr_q  <= thr_d;
        pend_q <= pend_d;
        endp_q <= endp_d;
      end
      grp_cnt_q  <= grp_cnt_d;
      grp_bad_q  <= grp_bad_d;
      grp_term_q <= grp_term_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_byte_q <= grp_byte_d;
  end

  a_bad_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.bad_lead |-> out_o.out_last && !out_o.is_terminator)
    else $error("error result not a single last result");

  a_term_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.is_terminator |-> out_o.out_byte == '0 && out_o.out_last)
    else $error("terminator not a closing zero byte");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input held without a pending result");

  a_bad_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (pend_q == '0) && (in_len == u2c_pkg::LenBad) |=> pend_q == '0 && !endp_q)
    else $error("bad lead byte left a sequence open");

endmodule
